### rtl/core/pps_pkg.sv
// shared types and constants for the priority process scheduler
// no dependencies
`timescale 1ns / 1ps
package pps_pkg;
  localparam int MaxProcesses = 8;
  localparam int IdxW = $clog2(MaxProcesses);
  localparam int CntW = $clog2(MaxProcesses + 1);
  localparam int ResultLimit = 32;
  localparam int ResCntW = 6;
  localparam int TimeW = 13;

  localparam logic [1:0] KIND_SLICE = 2'd0;
  localparam logic [1:0] KIND_IDLE  = 2'd1;
  localparam logic [1:0] KIND_WAIT  = 2'd2;

  localparam logic [11:0] AmountMax = 12'd4095;

  // one loaded process record
  typedef struct packed {
    logic [9:0] arrival;
    logic [7:0] burst;
    logic [7:0] prio;
    logic       is_final;
  } rec_t;

  // one result transaction
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  pid;
    logic [11:0] amount;
    logic        last;
  } res_t;
endpackage

### rtl/core/pps_front.sv
// front end: accepts process records into a short queue
// depends on pps_pkg
`timescale 1ns / 1ps
module pps_front
  import pps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [9:0] arrival_time,
  input  logic [7:0] burst_time,
  input  logic [7:0] priority_level,
  input  logic       is_final,
  output logic       q_valid,
  input  logic       q_ready,
  output rec_t       q_rec
);
  // two-entry queue
  rec_t       mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_rec    = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{arrival: arrival_time, burst: burst_time,
                      prio: priority_level, is_final: is_final};
    end
  end
endmodule

### rtl/core/pps_back.sv
// back end: stores records, runs the schedule, emits results
// depends on pps_pkg
`timescale 1ns / 1ps
module pps_back
  import pps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        mode,
  input  logic        q_valid,
  output logic        q_ready,
  input  rec_t        q_rec,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_res
);
  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_INIT = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_DEC  = 3'd3;
  localparam logic [2:0] ST_WAIT = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [9:0]  arr_r  [MaxProcesses];
  logic [7:0]  bur_r  [MaxProcesses];
  logic [7:0]  rem_r  [MaxProcesses];
  logic [7:0]  pri_r  [MaxProcesses];
  logic [TimeW-1:0] comp_r [MaxProcesses];

  logic [2:0]       st_r, st_nxt;
  logic [CntW-1:0]  n_r;
  logic [CntW-1:0]  i_r;
  logic [CntW-1:0]  left_r;
  logic [TimeW-1:0] t_r;
  logic             best_ok_r;
  logic [IdxW-1:0]  best_r;
  logic             nxt_ok_r;
  logic [9:0]       nxt_r;

  // pending merged result and produced count
  logic             pend_r;
  res_t             pend_res_r;
  logic [ResCntW-1:0] rcnt_r;

  // output register
  logic out_valid_r;
  res_t out_res_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  assign q_ready = (st_r == ST_LOAD);

  logic [IdxW-1:0] ii;
  assign ii = i_r[IdxW-1:0];

  // candidate compare for the scan
  logic cand_before;
  always_comb begin
    if (pri_r[ii] != pri_r[best_r]) cand_before = pri_r[ii] < pri_r[best_r];
    else cand_before = arr_r[ii] < arr_r[best_r];
  end

  // new result request from the scheduler
  logic [TimeW-1:0] run_amt;
  logic [TimeW-1:0] gap;
  logic [TimeW-1:0] spent, wait_t;
  logic        emit_free;
  logic [TimeW:0] merged;
  logic        room;
  logic        same_slice;
  logic        out_push;
  res_t        out_push_res;

  always_comb begin
    gap = {3'b0, nxt_r} - t_r;
    run_amt = {5'b0, rem_r[best_r]};
    if (mode && nxt_ok_r && gap < run_amt) run_amt = gap;
    spent = {3'b0, arr_r[ii]} + {5'b0, bur_r[ii]};
    wait_t = (comp_r[ii] > spent) ? comp_r[ii] - spent : '0;
  end

  assign emit_free = !pend_r || !out_valid_r || out_ready;
  assign merged = {2'b0, pend_res_r.amount} + {1'b0, run_amt};
  assign room = (rcnt_r != ResCntW'(ResultLimit));
  assign same_slice = pend_r && pend_res_r.kind == KIND_SLICE &&
                      pend_res_r.pid == 3'(best_r);

  // move the pending result into the output register
  always_comb begin
    out_push = 1'b0;
    out_push_res = pend_res_r;
    case (st_r)
      ST_DEC:  out_push = emit_free && pend_r && room && !(best_ok_r && same_slice);
      ST_WAIT: out_push = emit_free && i_r != n_r && pend_r && room;
      ST_EMIT: begin
        out_push = pend_r && (!out_valid_r || out_ready);
        out_push_res.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_LOAD: if (q_valid && q_rec.is_final) st_nxt = ST_INIT;
      ST_INIT: st_nxt = (left_r == '0) ? ST_WAIT : ST_SCAN;
      ST_SCAN: if (i_r == n_r) st_nxt = ST_DEC;
      ST_DEC: begin
        if (emit_free) begin
          st_nxt = (best_ok_r && rem_r[best_r] == run_amt[7:0] &&
                    left_r == CntW'(1)) ? ST_WAIT : ST_SCAN;
        end
      end
      ST_WAIT: if (emit_free && i_r == n_r) st_nxt = ST_EMIT;
      ST_EMIT: if (!pend_r && (!out_valid_r || out_ready)) st_nxt = ST_DONE;
      ST_DONE: st_nxt = ST_LOAD;
      default: st_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_LOAD;
      n_r <= '0;
      i_r <= '0;
      left_r <= '0;
      t_r <= '0;
      pend_r <= 1'b0;
      rcnt_r <= '0;
      out_valid_r <= 1'b0;
      best_ok_r <= 1'b0;
      nxt_ok_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_push) begin
        out_valid_r <= 1'b1;
        out_res_r <= out_push_res;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        // store records
        ST_LOAD: begin
          if (q_valid) begin
            if (n_r < CntW'(MaxProcesses)) begin
              arr_r[n_r[IdxW-1:0]] <= q_rec.arrival;
              bur_r[n_r[IdxW-1:0]] <= q_rec.burst;
              rem_r[n_r[IdxW-1:0]] <= q_rec.burst;
              pri_r[n_r[IdxW-1:0]] <= q_rec.prio;
              comp_r[n_r[IdxW-1:0]] <= {3'b0, q_rec.arrival};
              n_r <= n_r + 1'b1;
              if (q_rec.burst != 8'd0) left_r <= left_r + 1'b1;
            end
          end
        end
        ST_INIT: begin
          t_r <= '0;
          i_r <= '0;
          best_ok_r <= 1'b0;
          nxt_ok_r <= 1'b0;
          rcnt_r <= '0;
          pend_r <= 1'b0;
        end
        // one process per cycle
        ST_SCAN: begin
          if (i_r != n_r) begin
            if (rem_r[ii] != 8'd0) begin
              if ({3'b0, arr_r[ii]} <= t_r) begin
                if (!best_ok_r || cand_before) begin
                  best_r <= ii;
                  best_ok_r <= 1'b1;
                end
              end else if (!nxt_ok_r || arr_r[ii] < nxt_r) begin
                nxt_r <= arr_r[ii];
                nxt_ok_r <= 1'b1;
              end
            end
            i_r <= i_r + 1'b1;
          end
        end
        // apply decision and feed result
        ST_DEC: begin
          if (emit_free) begin
            i_r <= '0;
            best_ok_r <= 1'b0;
            nxt_ok_r <= 1'b0;
            if (!best_ok_r) begin
              t_r <= {3'b0, nxt_r};
              if (room) begin
                pend_r <= 1'b1;
                pend_res_r <= '{kind: KIND_IDLE, pid: 3'd0, amount: gap[11:0], last: 1'b0};
                rcnt_r <= rcnt_r + 1'b1;
              end
            end else begin
              t_r <= t_r + run_amt;
              rem_r[best_r] <= rem_r[best_r] - run_amt[7:0];
              if (rem_r[best_r] == run_amt[7:0]) begin
                comp_r[best_r] <= t_r + run_amt;
                left_r <= left_r - 1'b1;
              end
              if (same_slice) begin
                pend_res_r.amount <= (merged > {2'b0, AmountMax}) ? AmountMax
                                     : merged[11:0];
              end else if (room) begin
                pend_r <= 1'b1;
                pend_res_r <= '{kind: KIND_SLICE, pid: 3'(best_r),
                                amount: run_amt[11:0], last: 1'b0};
                rcnt_r <= rcnt_r + 1'b1;
              end
            end
          end
        end
        // waiting times in load order
        ST_WAIT: begin
          if (emit_free && i_r != n_r) begin
            if (room) begin
              pend_r <= 1'b1;
              pend_res_r <= '{kind: KIND_WAIT, pid: 3'(ii),
                              amount: wait_t[11:0], last: 1'b0};
              rcnt_r <= rcnt_r + 1'b1;
            end
            i_r <= i_r + 1'b1;
          end
        end
        // flush final result with last flag
        ST_EMIT: begin
          if (pend_r && (!out_valid_r || out_ready)) pend_r <= 1'b0;
        end
        ST_DONE: begin
          n_r <= '0;
          left_r <= '0;
          t_r <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule

### rtl/core/priority_process_scheduler.sv
// top level of the priority process scheduler
// depends on pps_pkg, pps_front, pps_back
//
// channel  | ports                                              | direction
// in_      | in_valid/in_ready, arrival_time..is_final          | records in
// out_     | out_valid/out_ready, result_kind..last_result      | results out
// cfg_     | cfg_valid/cfg_ready, cfg_preemptive_mode           | mode write
//
// records load one per cycle through a two-entry queue while it has room
// the final record starts a run: each decision scans the n held records,
// one per cycle, then applies the choice, waiting while the output is stalled;
// waiting times follow in load order; results stall only on out_ready;
// synchronous active-low reset clears control and sets non-preemptive mode
`timescale 1ns / 1ps
module priority_process_scheduler
  import pps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [9:0]  arrival_time,
  input  logic [7:0]  burst_time,
  input  logic [7:0]  priority_level,
  input  logic        is_final,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [2:0]  process_id,
  output logic [11:0] amount,
  output logic        last_result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_preemptive_mode
);
  logic mode_r;
  logic q_valid, q_ready;
  rec_t q_rec;
  res_t res;

  // mode register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= 1'b0;
    else if (cfg_valid) mode_r <= cfg_preemptive_mode;
  end

  pps_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .arrival_time, .burst_time,
    .priority_level, .is_final, .q_valid, .q_ready, .q_rec
  );

  pps_back u_back (
    .clk, .rst_n, .mode(mode_r), .q_valid, .q_ready, .q_rec,
    .out_valid, .out_ready, .out_res(res)
  );

  assign result_kind = res.kind;
  assign process_id  = res.pid;
  assign amount      = res.amount;
  assign last_result = res.last;
endmodule
